@@ sv/rv32_pkg.sv @@
// Shared types, opcodes and constants for the rv32im step core.
`timescale 1ns / 1ps
`default_nettype none
package rv32_pkg;

  localparam int unsigned DmemWordsDefault = 16384;
  localparam int unsigned PcBitsDefault    = 16;
  localparam int unsigned XLEN             = 32;

  localparam logic [6:0] OP_IO     = 7'b0001011;
  localparam logic [6:0] OP_LUI    = 7'b0110111;
  localparam logic [6:0] OP_AUIPC  = 7'b0010111;
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_JALR   = 7'b1100111;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_IMM    = 7'b0010011;
  localparam logic [6:0] OP_REG    = 7'b0110011;

  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;
  localparam logic [6:0] F7_MUL  = 7'b0000001;

  // Operation codes for the shared execution unit
  typedef enum logic [3:0] {
    ALU_ADD  = 4'd0,
    ALU_SUB  = 4'd1,
    ALU_SLL  = 4'd2,
    ALU_SLT  = 4'd3,
    ALU_SLTU = 4'd4,
    ALU_XOR  = 4'd5,
    ALU_OR   = 4'd6,
    ALU_AND  = 4'd7,
    ALU_SRA  = 4'd8,
    ALU_MUL  = 4'd9,
    ALU_DIV  = 4'd10
  } alu_op_t;

  // Start request into the execution unit
  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  // Completion status out of the execution unit
  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } alu_rsp_t;

endpackage
`default_nettype wire

@@ sv/rv32_alu.sv @@
// Shared execution unit: registered logic ops, iterative multiply and divide.
`timescale 1ns / 1ps
`default_nettype none
module rv32_alu (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rv32_pkg::alu_req_t req,
  input  wire logic [31:0]       a,
  input  wire logic [31:0]       b,
  output rv32_pkg::alu_rsp_t     rsp
);
  import rv32_pkg::*;

  logic        busy_r, busy_nxt;
  alu_op_t     op_r, op_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] acc_r, acc_nxt;     // product or remainder
  logic [31:0] q_r, q_nxt;         // multiplier bits or quotient
  logic [31:0] d_r, d_nxt;         // multiplicand or divisor magnitude
  logic        neg_r, neg_nxt;
  logic        done_r, done_nxt;
  logic [31:0] res_r, res_nxt;

  logic [31:0] ua, ub, sra_v;
  logic [32:0] rem_sh, diff;

  assign ua    = a[31] ? (32'd0 - a) : a;
  assign ub    = b[31] ? (32'd0 - b) : b;
  assign sra_v = $signed(a) >>> b[4:0];
  assign rem_sh = {acc_r, q_r[31]};
  assign diff   = rem_sh - {1'b0, d_r};

  // Sequence one operation; multiply and divide take one bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    if (req.start) begin
      unique case (req.op)
        ALU_ADD:  begin res_nxt = a + b; done_nxt = 1'b1; end
        ALU_SUB:  begin res_nxt = a - b; done_nxt = 1'b1; end
        ALU_SLL:  begin res_nxt = a << b[4:0]; done_nxt = 1'b1; end
        ALU_SLT:  begin
          res_nxt = {31'd0, $signed(a) < $signed(b)}; done_nxt = 1'b1;
        end
        ALU_SLTU: begin res_nxt = {31'd0, a < b}; done_nxt = 1'b1; end
        ALU_XOR:  begin res_nxt = a ^ b; done_nxt = 1'b1; end
        ALU_OR:   begin res_nxt = a | b; done_nxt = 1'b1; end
        ALU_AND:  begin res_nxt = a & b; done_nxt = 1'b1; end
        ALU_SRA:  begin res_nxt = sra_v; done_nxt = 1'b1; end
        ALU_MUL:  begin
          busy_nxt = 1'b1; op_nxt = ALU_MUL; cnt_nxt = 6'd0;
          acc_nxt = 32'd0; q_nxt = b; d_nxt = a;
        end
        ALU_DIV:  begin
          if (b == 32'd0) begin
            res_nxt = '1; done_nxt = 1'b1;
          end else begin
            busy_nxt = 1'b1; op_nxt = ALU_DIV; cnt_nxt = 6'd0;
            acc_nxt = 32'd0; q_nxt = ua; d_nxt = ub;
            neg_nxt = a[31] ^ b[31];
          end
        end
        default: begin res_nxt = 32'd0; done_nxt = 1'b1; end
      endcase
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 6'd1;
      if (op_r == ALU_MUL) begin
        // Shift-add, low 32 bits of the product only
        if (q_r[0]) acc_nxt = acc_r + d_r;
        q_nxt = q_r >> 1;
        d_nxt = d_r << 1;
      end else begin
        // Restoring division, one quotient bit per cycle
        if (!diff[32]) begin
          acc_nxt = diff[31:0];
          q_nxt   = {q_r[30:0], 1'b1};
        end else begin
          acc_nxt = rem_sh[31:0];
          q_nxt   = {q_r[30:0], 1'b0};
        end
      end
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (op_r == ALU_MUL) res_nxt = acc_nxt;
        else res_nxt = neg_r ? (32'd0 - q_nxt) : q_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= ALU_ADD;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;
endmodule
`default_nettype wire

@@ sv/rv32im_core_step.sv @@
// Top level of the rv32im step core: decode, register file, data memory, sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Executes one instruction per accepted input transfer. The core reads both
// source registers, starts the shared execution unit, waits for it, performs
// the memory access if any and writes back, then offers one result transfer.
// Instructions that skip the execution unit (I/O, lui, auipc, jal, branches,
// illegal forms) go from the register read straight to writeback. Other ALU
// operations, jalr and stores wait on the unit; loads then add a state for the
// registered memory read. mul and div run through the 32 one-bit steps of the
// shared multiply/divide unit; a division by zero skips them. The core only
// accepts again after each result transfer, so it holds one instruction at a
// time. Data memory holds no reset value, and loading an unwritten word
// gives an undefined value. DMEM_WORDS is expected to be a power of two.
module rv32im_core_step #(
  parameter int unsigned DMEM_WORDS = rv32_pkg::DmemWordsDefault,
  parameter int unsigned PC_BITS    = rv32_pkg::PcBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_instruction,
  input  wire logic [7:0]  in_in_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_next_pc,
  output logic             out_out_valid,
  output logic [7:0]       out_out_byte,
  output logic             out_took_input,
  output logic             out_illegal
);
  import rv32_pkg::*;

  localparam int unsigned AW = $clog2(DMEM_WORDS);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_EXEC = 7'b0000100,
    S_WAIT = 7'b0001000,
    S_MEM  = 7'b0010000,
    S_WB   = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0] rf [32];
  logic [31:0] ins_r;
  logic [7:0]  inb_r;
  logic [31:0] a_r, b_r, d_r;
  logic [31:0] res_r;
  logic [31:0] mem_q_r;
  logic [PC_BITS-1:0] pc_r;
  logic [PC_BITS-1:0] npc_r;
  logic        ov_r, took_r, ill_r;
  logic [7:0]  ob_r;
  logic [31:0] dmem [DMEM_WORDS];

  // Field decode
  logic [6:0]  op;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  rd;
  logic [31:0] immi, imms, immb, immj;
  assign op   = ins_r[6:0];
  assign f3   = ins_r[14:12];
  assign f7   = ins_r[31:25];
  assign rd   = ins_r[11:7];
  assign immi = {{20{ins_r[31]}}, ins_r[31:20]};
  assign imms = {{20{ins_r[31]}}, ins_r[31:25], ins_r[11:7]};
  assign immb = {{20{ins_r[31]}}, ins_r[7], ins_r[30:25], ins_r[11:8], 1'b0};
  assign immj = {{12{ins_r[31]}}, ins_r[19:12], ins_r[20], ins_r[30:21], 1'b0};

  // Classify the instruction and pick the execution unit operation
  alu_op_t     alu_op;
  logic [31:0] alu_b;
  logic        dec_ill, uses_alu, wr_alu;
  always_comb begin
    alu_op = ALU_ADD; alu_b = b_r; dec_ill = 1'b0; uses_alu = 1'b0; wr_alu = 1'b0;
    unique case (op)
      OP_JALR: begin
        uses_alu = 1'b1; alu_b = immi; dec_ill = (f3 != 3'd0);
      end
      OP_LOAD: begin
        uses_alu = 1'b1; alu_b = immi;
        dec_ill = (f3 == 3'd3) || (f3 == 3'd6) || (f3 == 3'd7);
      end
      OP_STORE: begin
        uses_alu = 1'b1; alu_b = imms; dec_ill = (f3 > 3'd2);
      end
      OP_IMM: begin
        uses_alu = 1'b1; wr_alu = 1'b1; alu_b = immi;
        case (f3)
          3'd0: alu_op = ALU_ADD;
          3'd1: alu_op = ALU_SLL;
          3'd2: alu_op = ALU_SLT;
          3'd3: alu_op = ALU_SLTU;
          3'd4: alu_op = ALU_XOR;
          3'd6: alu_op = ALU_OR;
          3'd7: alu_op = ALU_AND;
          default: dec_ill = 1'b1;
        endcase
      end
      OP_REG: begin
        uses_alu = 1'b1; wr_alu = 1'b1;
        if (f7 == F7_BASE) begin
          case (f3)
            3'd0: alu_op = ALU_ADD;
            3'd1: alu_op = ALU_SLL;
            3'd2: alu_op = ALU_SLT;
            3'd3: alu_op = ALU_SLTU;
            3'd4: alu_op = ALU_XOR;
            3'd6: alu_op = ALU_OR;
            3'd7: alu_op = ALU_AND;
            default: dec_ill = 1'b1;
          endcase
        end else if (f7 == F7_ALT && f3 == 3'd0) alu_op = ALU_SUB;
        else if (f7 == F7_ALT && f3 == 3'd5) alu_op = ALU_SRA;
        else if (f7 == F7_MUL && f3 == 3'd0) alu_op = ALU_MUL;
        else if (f7 == F7_MUL && f3 == 3'd4) alu_op = ALU_DIV;
        else dec_ill = 1'b1;
      end
      OP_IO, OP_LUI, OP_AUIPC, OP_JAL, OP_BRANCH: dec_ill = 1'b0;
      default: dec_ill = 1'b1;
    endcase
  end

  // Branch compare
  logic take;
  logic br_ill;
  always_comb begin
    take = 1'b0; br_ill = 1'b0;
    case (f3)
      3'd0: take = (a_r == b_r);
      3'd1: take = (a_r != b_r);
      3'd4: take = $signed(a_r) < $signed(b_r);
      3'd5: take = !($signed(a_r) < $signed(b_r));
      3'd6: take = a_r < b_r;
      3'd7: take = a_r >= b_r;
      default: br_ill = 1'b1;
    endcase
  end

  alu_req_t req;
  alu_rsp_t rsp;
  assign req.start = (state_r == S_EXEC) && uses_alu && !dec_ill;
  assign req.op    = alu_op;

  rv32_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .a     (a_r),
    .b     (alu_b),
    .rsp   (rsp)
  );

  logic [PC_BITS-1:0] pc_inc, pc_br, pc_j;
  assign pc_inc = pc_r + PC_BITS'(1);
  assign pc_br  = pc_r + immb[PC_BITS+1:2];
  assign pc_j   = pc_r + immj[PC_BITS+1:2];

  logic [31:0] link;
  assign link = {{(30-PC_BITS){1'b0}}, pc_inc, 2'b00};

  logic [AW-1:0] maddr;
  assign maddr = res_r[AW+1:2];

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_READ;
      S_READ: state_nxt = S_EXEC;
      S_EXEC: state_nxt = (uses_alu && !dec_ill) ? S_WAIT : S_WB;
      S_WAIT: if (rsp.done) state_nxt = (op == OP_LOAD) ? S_MEM : S_WB;
      S_MEM:  state_nxt = S_WB;
      S_WB:   state_nxt = S_OUT;
      S_OUT:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Writeback value and next pc
  logic        wen;
  logic [31:0] wdata;
  logic [PC_BITS-1:0] npc;
  logic        ill;
  always_comb begin
    wen = 1'b0; wdata = res_r; npc = pc_inc; ill = dec_ill;
    if (!dec_ill) begin
      unique case (op)
        OP_IO:    begin wen = !ins_r[12]; wdata = {d_r[31:8], inb_r}; end
        OP_LUI:   begin wen = 1'b1; wdata = {ins_r[31:12], 12'd0}; end
        OP_AUIPC: begin
          wen = 1'b1;
          wdata = {ins_r[31:12], 12'd0} + {{(30-PC_BITS){1'b0}}, pc_r, 2'b00};
        end
        OP_JAL:   begin wen = 1'b1; wdata = link; npc = pc_j; end
        OP_JALR:  begin wen = 1'b1; wdata = link; npc = res_r[PC_BITS+1:2]; end
        OP_BRANCH: begin ill = br_ill; if (take) npc = pc_br; end
        OP_LOAD: begin
          wen = 1'b1;
          case (f3)
            3'd0: wdata = {{24{mem_q_r[7]}}, mem_q_r[7:0]};
            3'd1: wdata = {{16{mem_q_r[15]}}, mem_q_r[15:0]};
            3'd4: wdata = {24'd0, mem_q_r[7:0]};
            3'd5: wdata = {16'd0, mem_q_r[15:0]};
            default: wdata = mem_q_r;
          endcase
        end
        OP_IMM, OP_REG: wen = wr_alu;
        default: wen = 1'b0;
      endcase
    end
  end

  logic [31:0] st_data;
  always_comb begin
    case (f3)
      3'd0: st_data = {24'd0, b_r[7:0]};
      3'd1: st_data = {16'd0, b_r[15:0]};
      default: st_data = b_r;
    endcase
  end

  // Data memory: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (state_r == S_WB && op == OP_STORE && !dec_ill) dmem[maddr] <= st_data;
    if (state_r == S_MEM) mem_q_r <= dmem[maddr];
  end

  // Register file, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) rf[i] <= 32'd0;
    end else if (state_r == S_WB && wen && rd != 5'd0) begin
      rf[rd] <= wdata;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_WB) pc_r <= npc;
    end
  end

  // Payload capture
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      ins_r <= in_instruction;
      inb_r <= in_in_byte;
    end
    if (state_r == S_READ) begin
      a_r <= rf[ins_r[19:15]];
      b_r <= rf[ins_r[24:20]];
      d_r <= rf[ins_r[11:7]];
    end
    if (rsp.done) res_r <= rsp.result;
    if (state_r == S_WB) begin
      npc_r  <= npc;
      ill_r  <= ill;
      ov_r   <= !dec_ill && op == OP_IO && ins_r[12];
      ob_r   <= (!dec_ill && op == OP_IO && ins_r[12]) ? a_r[7:0] : 8'd0;
      took_r <= !dec_ill && op == OP_IO && !ins_r[12];
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = (state_r == S_OUT);
  assign out_next_pc    = 16'(npc_r);
  assign out_out_valid  = ov_r;
  assign out_out_byte   = ob_r;
  assign out_took_input = took_r;
  assign out_illegal    = ill_r;

  // Execution unit only completes while the sequencer waits on it
  assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (state_r == S_WAIT)) else $error("alu done outside wait");
  // Pc changes only right after writeback
  assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r != $past(pc_r)) |-> $past(state_r == S_WB)) else $error("pc moved");
  // Result presented exactly after writeback
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_WB)) else $error("result early");
endmodule
`default_nettype wire

@@ test/rv32im_core_step_test.sv @@
// Self-checking testbench for the rv32im step core with an instruction-level predictor.
`timescale 1ns / 1ps
module rv32im_core_step_test;
  import rv32_pkg::*;

  localparam int unsigned MemWords   = DmemWordsDefault;
  localparam int unsigned NumRandom  = 430;
  localparam int unsigned CycleLimit = 600000;

  // One result transfer as the core reports it
  typedef struct {
    bit [15:0] next_pc;
    bit        io_valid;
    bit [7:0]  io_byte;
    bit        took;
    bit        illegal;
  } step_res_t;

  // Architectural shadow of the core; predicts each step and checks results
  class core_scoreboard;
    bit [31:0] regs [32];
    bit [15:0] pc;
    bit [31:0] mem [int unsigned];
    int unsigned low_words [$];
    step_res_t pending_q [$];
    int errors, n_in, n_out, n_emit, n_illegal;

    function bit [31:0] rd_reg(bit [4:0] i);
      return (i == 0) ? 32'h0 : regs[i];
    endfunction

    function void wr_reg(bit [4:0] i, bit [31:0] v);
      if (i != 0) regs[i] = v;
    endfunction

    function int unsigned word_of(bit [31:0] addr);
      return (addr >> 2) % MemWords;
    endfunction

    // Word index a load instruction would read, given the current registers
    function int unsigned load_word(bit [31:0] ins);
      return word_of(rd_reg(ins[19:15]) + {{20{ins[31]}}, ins[31:20]});
    endfunction

    function bit load_safe(bit [31:0] ins);
      if (ins[6:0] != OP_LOAD) return 1;
      return mem.exists(load_word(ins));
    endfunction

    // Predict one accepted instruction and queue its result
    function void note(bit [31:0] ins, bit [7:0] inb);
      bit [6:0]  op, f7;
      bit [2:0]  f3;
      bit [4:0]  rd, sh;
      bit [31:0] a, b, immi, imm, w, ua, ub, q;
      bit [15:0] npc;
      bit        take;
      int unsigned idx;
      step_res_t r;
      op = ins[6:0]; f3 = ins[14:12]; f7 = ins[31:25]; rd = ins[11:7];
      a = rd_reg(ins[19:15]); b = rd_reg(ins[24:20]);
      immi = {{20{ins[31]}}, ins[31:20]};
      npc = pc + 16'd1;
      sh = b[4:0];
      r = '{default: 0};
      case (op)
        OP_IO: begin
          if (!ins[12]) begin
            w = rd_reg(rd);
            wr_reg(rd, {w[31:8], inb});
            r.took = 1;
          end else begin
            r.io_valid = 1;
            r.io_byte = a[7:0];
          end
        end
        OP_LUI:   wr_reg(rd, {ins[31:12], 12'h0});
        OP_AUIPC: wr_reg(rd, {ins[31:12], 12'h0} + {14'h0, pc, 2'b00});
        OP_JAL: begin
          imm = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
          wr_reg(rd, {14'h0, npc, 2'b00});
          npc = pc + 16'($signed(imm) >>> 2);
        end
        OP_BRANCH: begin
          imm = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
          take = 0;
          case (f3)
            3'd0: take = (a == b);
            3'd1: take = (a != b);
            3'd4: take = $signed(a) < $signed(b);
            3'd5: take = !($signed(a) < $signed(b));
            3'd6: take = a < b;
            3'd7: take = a >= b;
            default: r.illegal = 1;
          endcase
          if (take) npc = pc + 16'($signed(imm) >>> 2);
        end
        OP_LOAD: begin
          idx = word_of(a + immi);
          w = mem.exists(idx) ? mem[idx] : 32'h0;
          case (f3)
            3'd0: wr_reg(rd, {{24{w[7]}}, w[7:0]});
            3'd1: wr_reg(rd, {{16{w[15]}}, w[15:0]});
            3'd2: wr_reg(rd, w);
            3'd4: wr_reg(rd, {24'h0, w[7:0]});
            3'd5: wr_reg(rd, {16'h0, w[15:0]});
            default: r.illegal = 1;
          endcase
        end
        OP_STORE: begin
          idx = word_of(a + {{20{ins[31]}}, ins[31:25], ins[11:7]});
          if (f3 > 3'd2) begin
            r.illegal = 1;
          end else begin
            if (!mem.exists(idx) && idx < 512) low_words.push_back(idx);
            mem[idx] = (f3 == 3'd0) ? {24'h0, b[7:0]} :
                       (f3 == 3'd1) ? {16'h0, b[15:0]} : b;
          end
        end
        OP_IMM: begin
          case (f3)
            3'd0: wr_reg(rd, a + immi);
            3'd1: wr_reg(rd, a << immi[4:0]);
            3'd2: wr_reg(rd, ($signed(a) < $signed(immi)) ? 32'd1 : 32'd0);
            3'd3: wr_reg(rd, (a < immi) ? 32'd1 : 32'd0);
            3'd4: wr_reg(rd, a ^ immi);
            3'd6: wr_reg(rd, a | immi);
            3'd7: wr_reg(rd, a & immi);
            default: r.illegal = 1;
          endcase
        end
        OP_REG: begin
          if (f7 == F7_BASE) begin
            case (f3)
              3'd0: wr_reg(rd, a + b);
              3'd1: wr_reg(rd, a << sh);
              3'd2: wr_reg(rd, ($signed(a) < $signed(b)) ? 32'd1 : 32'd0);
              3'd3: wr_reg(rd, (a < b) ? 32'd1 : 32'd0);
              3'd4: wr_reg(rd, a ^ b);
              3'd6: wr_reg(rd, a | b);
              3'd7: wr_reg(rd, a & b);
              default: r.illegal = 1;
            endcase
          end else if (f7 == F7_ALT && f3 == 3'd0) begin
            wr_reg(rd, a - b);
          end else if (f7 == F7_ALT && f3 == 3'd5) begin
            wr_reg(rd, $unsigned($signed(a) >>> sh));
          end else if (f7 == F7_MUL && f3 == 3'd0) begin
            wr_reg(rd, a * b);
          end else if (f7 == F7_MUL && f3 == 3'd4) begin
            // signed divide: all ones on zero divisor, overflow wraps
            if (b == 0) begin
              q = 32'hFFFF_FFFF;
            end else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
              q = 32'h8000_0000;
            end else begin
              ua = a[31] ? -a : a;
              ub = b[31] ? -b : b;
              q = ua / ub;
              if (a[31] ^ b[31]) q = -q;
            end
            wr_reg(rd, q);
          end else begin
            r.illegal = 1;
          end
        end
        default: begin
          if (op == OP_JALR && f3 == 3'd0) begin
            w = a + immi;
            wr_reg(rd, {14'h0, npc, 2'b00});
            npc = w[17:2];
          end else begin
            r.illegal = 1;
          end
        end
      endcase
      pc = npc;
      r.next_pc = npc;
      pending_q.push_back(r);
      n_in++;
      if (r.illegal) n_illegal++;
    endfunction

    // Compare one result transfer against the oldest prediction
    function void check(step_res_t act);
      step_res_t e;
      n_out++;
      if (act.io_valid) n_emit++;
      if (pending_q.size() == 0) begin
        $error("result with no instruction outstanding: next_pc=%h", act.next_pc);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (act.next_pc !== e.next_pc) begin
        $error("next_pc: expected %h actual %h", e.next_pc, act.next_pc);
        errors++;
      end
      if (act.io_valid !== e.io_valid) begin
        $error("out_valid: expected %0d actual %0d", e.io_valid, act.io_valid);
        errors++;
      end
      if (act.io_byte !== e.io_byte) begin
        $error("out_byte: expected %h actual %h", e.io_byte, act.io_byte);
        errors++;
      end
      if (act.took !== e.took) begin
        $error("took_input: expected %0d actual %0d", e.took, act.took);
        errors++;
      end
      if (act.illegal !== e.illegal) begin
        $error("illegal: expected %0d actual %0d", e.illegal, act.illegal);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_instruction;
  logic [7:0]  in_in_byte;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_next_pc;
  logic        out_out_valid;
  logic [7:0]  out_out_byte;
  logic        out_took_input;
  logic        out_illegal;

  core_scoreboard sb;
  int unsigned cycle_cnt;
  int unsigned stall_left;
  bit          no_stall_phase;
  bit          no_gap_phase;

  rv32im_core_step i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_instruction(in_instruction),
    .in_in_byte    (in_in_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_next_pc   (out_next_pc),
    .out_out_valid (out_out_valid),
    .out_out_byte  (out_out_byte),
    .out_took_input(out_took_input),
    .out_illegal   (out_illegal)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Instruction encoders
  function automatic bit [31:0] enc_r(bit [6:0] f7, bit [4:0] rs2, bit [4:0] rs1,
                                      bit [2:0] f3, bit [4:0] rd, bit [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic bit [31:0] enc_i(bit [11:0] imm, bit [4:0] rs1, bit [2:0] f3,
                                      bit [4:0] rd, bit [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic bit [31:0] enc_s(bit [11:0] imm, bit [4:0] rs2, bit [4:0] rs1,
                                      bit [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
  endfunction

  function automatic bit [31:0] enc_b(bit [12:0] imm, bit [4:0] rs2, bit [4:0] rs1,
                                      bit [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
  endfunction

  function automatic bit [31:0] enc_j(bit [20:0] imm, bit [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
  endfunction

  function automatic bit [4:0] rreg();
    return 5'($urandom_range(0, 31));
  endfunction

  // Random instruction with a weighted mix of classes
  function automatic bit [31:0] rand_instr();
    int unsigned k;
    bit [2:0] f3;
    k = $urandom_range(0, 99);
    f3 = 3'($urandom_range(0, 7));
    if (k < 10) return enc_i(12'($urandom), rreg(), 3'($urandom_range(0, 1)), rreg(), OP_IO);
    if (k < 16) return {20'($urandom), rreg(), ($urandom_range(0, 1) ? OP_LUI : OP_AUIPC)};
    if (k < 21) return enc_j(21'($urandom), rreg());
    if (k < 25) return enc_i(12'($urandom), rreg(), ($urandom_range(0, 5) == 0) ? f3 : 3'd0,
                             rreg(), OP_JALR);
    if (k < 34) return enc_b(13'($urandom), rreg(), rreg(), f3);
    if (k < 46) return enc_i($urandom_range(0, 1) ? 12'($urandom_range(0, 511) * 4 +
                             $urandom_range(0, 3)) : 12'($urandom), $urandom_range(0, 1) ?
                             5'd0 : rreg(), f3, rreg(), OP_LOAD);
    if (k < 58) return enc_s($urandom_range(0, 1) ? 12'($urandom_range(0, 2047)) :
                             12'($urandom), rreg(), $urandom_range(0, 2) ? 5'd0 : rreg(),
                             3'($urandom_range(0, 3)));
    if (k < 72) return enc_i(12'($urandom), rreg(), f3, rreg(), OP_IMM);
    if (k < 84) return enc_r($urandom_range(0, 1) ? F7_BASE : F7_ALT, rreg(), rreg(), f3,
                             rreg(), OP_REG);
    if (k < 92) return enc_r(($urandom_range(0, 9) == 0) ? 7'($urandom) : F7_MUL, rreg(),
                             rreg(), $urandom_range(0, 1) ? 3'd0 : 3'd4, rreg(), OP_REG);
    return $urandom;
  endfunction

  // Redirect a load that would read a never-written word, or turn it into a store
  function automatic bit [31:0] make_safe(bit [31:0] ins);
    int unsigned w;
    if (sb.load_safe(ins)) return ins;
    if (sb.low_words.size() == 0) return enc_s(12'($urandom_range(0, 2047)), ins[11:7], 5'd0,
                                               3'd2);
    w = sb.low_words[$urandom_range(0, sb.low_words.size() - 1)];
    return enc_i(12'(w * 4 + $urandom_range(0, 3)), 5'd0, ins[14:12], ins[11:7], OP_LOAD);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one instruction, hold it until the transfer, then idle for a random gap
  task automatic send(bit [31:0] ins, bit [7:0] inb);
    int unsigned gap;
    ins = make_safe(ins);
    in_instruction <= ins;
    in_in_byte     <= inb;
    in_valid       <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note(ins, inb);
    gap = no_gap_phase ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!no_stall_phase && $urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Check each result transfer
  always @(posedge clk) begin
    step_res_t act;
    if (rst_n && out_valid && out_ready) begin
      act.next_pc  = out_next_pc;
      act.io_valid = out_out_valid;
      act.io_byte  = out_out_byte;
      act.took     = out_took_input;
      act.illegal  = out_illegal;
      sb.check(act);
    end
  end

  // Guard against a hang
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout with %0d results outstanding", sb.pending_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    sb = new();
    cycle_cnt      = 0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_instruction = '0;
    in_in_byte     = '0;
    out_ready      = 1'b0;
    no_stall_phase = 1'b0;
    no_gap_phase   = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: I/O, divide corner cases, shifts, sub-word memory, jumps, illegal forms
    send(enc_i(12'h000, 5'd0, 3'd0, 5'd5, OP_IO), 8'hFF);
    send(enc_i(12'h000, 5'd0, 3'd0, 5'd6, OP_IO), 8'h00);
    send(enc_i(12'h000, 5'd5, 3'd1, 5'd0, OP_IO), 8'h5A);
    send({20'h80000, 5'd1, OP_LUI}, 8'h00);
    send(enc_i(12'hFFF, 5'd0, 3'd0, 5'd2, OP_IMM), 8'h00);
    send(enc_r(F7_MUL, 5'd2, 5'd1, 3'd4, 5'd3, OP_REG), 8'h00);
    send(enc_r(F7_MUL, 5'd0, 5'd1, 3'd4, 5'd4, OP_REG), 8'h00);
    send(enc_r(F7_MUL, 5'd2, 5'd2, 3'd0, 5'd7, OP_REG), 8'h00);
    send(enc_r(F7_ALT, 5'd2, 5'd1, 3'd5, 5'd8, OP_REG), 8'h00);
    send(enc_r(F7_BASE, 5'd2, 5'd2, 3'd1, 5'd9, OP_REG), 8'h00);
    send(enc_r(F7_BASE, 5'd0, 5'd1, 3'd2, 5'd10, OP_REG), 8'h00);
    send(enc_r(F7_ALT, 5'd2, 5'd0, 3'd0, 5'd11, OP_REG), 8'h00);
    send(enc_i(12'hFFF, 5'd2, 3'd1, 5'd12, OP_IMM), 8'h00);
    send(enc_i(12'hFFF, 5'd1, 3'd2, 5'd13, OP_IMM), 8'h00);
    send(enc_s(12'd0, 5'd2, 5'd0, 3'd2), 8'h00);
    send(enc_s(12'd4, 5'd2, 5'd0, 3'd0), 8'h00);
    send(enc_s(12'd8, 5'd2, 5'd0, 3'd1), 8'h00);
    send(enc_i(12'd4, 5'd0, 3'd0, 5'd14, OP_LOAD), 8'h00);
    send(enc_i(12'd8, 5'd0, 3'd1, 5'd14, OP_LOAD), 8'h00);
    send(enc_i(12'd4, 5'd0, 3'd4, 5'd15, OP_LOAD), 8'h00);
    send(enc_i(12'd9, 5'd0, 3'd5, 5'd16, OP_LOAD), 8'h00);
    send(enc_i(12'd5, 5'd0, 3'd0, 5'd0, OP_IMM), 8'h00);
    send({20'hFFFFF, 5'd17, OP_AUIPC}, 8'h00);
    send(enc_j(21'h1FFFF0, 5'd18), 8'h00);
    send(enc_j(21'd2, 5'd18), 8'h00);
    send(enc_i(12'd1, 5'd2, 3'd0, 5'd2, OP_JALR), 8'h00);
    send(enc_b(13'h1FFC, 5'd2, 5'd1, 3'd4), 8'h00);
    send(enc_b(13'd6, 5'd0, 5'd1, 3'd7), 8'h00);
    send(enc_b(13'd8, 5'd0, 5'd0, 3'd2), 8'h00);
    send(32'h0000_0053, 8'h00);
    send(enc_i(12'd0, 5'd1, 3'd1, 5'd3, OP_JALR), 8'h00);
    send(enc_i(12'd1, 5'd1, 3'd5, 5'd3, OP_IMM), 8'h00);
    send(enc_r(7'h7F, 5'd1, 5'd1, 3'd0, 5'd3, OP_REG), 8'h00);

    // Random: stretches with or without input idling and output stalls, picked at random
    for (int i = 0; i < NumRandom; i++) begin
      if (i % 60 == 0) begin
        no_gap_phase   = ($urandom_range(0, 3) == 0);
        no_stall_phase = ($urandom_range(0, 3) == 0);
      end
      send(rand_instr(), 8'($urandom));
    end
    in_valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("ran %0d instructions, %0d results, %0d bytes emitted, %0d illegal",
             sb.n_in, sb.n_out, sb.n_emit, sb.n_illegal);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/rv32_pkg.sv
sv/rv32_alu.sv
sv/rv32im_core_step.sv
test/rv32im_core_step_test.sv
